/* hw/rtl/bmp2rgb_pkg.sv */
package bmp2rgb_pkg;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_SKIP   = 2'd1,
    PH_PIXELS = 2'd2,
    PH_HALT   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_WINDOW = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_SIGNATURE = 2'd0,
    ERR_FORMAT    = 2'd1,
    ERR_SIZE      = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    REG_ORIGIN_X = 2'd0,
    REG_ORIGIN_Y = 2'd1,
    REG_DISP_W   = 2'd2,
    REG_DISP_H   = 2'd3
  } reg_e;

  localparam logic [15:0] BMP_SIGNATURE      = 16'h4D42;
  localparam logic [15:0] BMP_PLANES         = 16'd1;
  localparam logic [15:0] BMP_BITS_PER_PIXEL = 16'd24;

  localparam logic [15:0] DISP_W_RESET = 16'd240;
  localparam logic [15:0] DISP_H_RESET = 16'd320;

  // header byte positions at which a little-endian field is complete
  localparam logic [31:0] POS_SIGNATURE   = 32'd1;
  localparam logic [31:0] POS_OFFSET      = 32'd13;
  localparam logic [31:0] POS_WIDTH       = 32'd21;
  localparam logic [31:0] POS_HEIGHT      = 32'd25;
  localparam logic [31:0] POS_PLANES      = 32'd27;
  localparam logic [31:0] POS_DEPTH       = 32'd29;
  localparam logic [31:0] POS_COMPRESSION = 32'd33;
  localparam logic [31:0] HEADER_LEN      = 32'd34;

  typedef struct packed {
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [15:0] disp_w;
    logic [15:0] disp_h;
  } cfg_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] pixel_word;
    logic [15:0] x0;
    logic [15:0] y0;
    logic [16:0] x1;
    logic [16:0] y1;
    err_e        err;
  } result_t;

  // rgb565 with the two bytes of the word swapped
  function automatic logic [15:0] rgb565_swapped(input logic [7:0] blue,
                                                 input logic [7:0] green,
                                                 input logic [7:0] red);
    logic [15:0] w;
    w = {red[7:3], green[7:2], blue[7:3]};
    return {w[7:0], w[15:8]};
  endfunction

endpackage

/* hw/rtl/bmp2rgb_in_if.sv */
interface bmp2rgb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_image;

  modport source (output valid, output data_byte, output start_of_image, input ready);
  modport sink   (input valid, input data_byte, input start_of_image, output ready);
endinterface

/* hw/rtl/bmp2rgb_out_if.sv */
interface bmp2rgb_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [15:0] pixel_word;
  logic [15:0] window_x0;
  logic [15:0] window_y0;
  logic [16:0] window_x1;
  logic [16:0] window_y1;
  logic [1:0]  error_code;

  modport source (
    output valid, output result_kind, output pixel_word, output window_x0,
    output window_y0, output window_x1, output window_y1, output error_code,
    input ready
  );
  modport sink (
    input valid, input result_kind, input pixel_word, input window_x0,
    input window_y0, input window_x1, input window_y1, input error_code,
    output ready
  );
endinterface

/* hw/rtl/bmp2rgb_parser.sv */
module bmp2rgb_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 acc_i,
  input  logic [7:0]           byte_i,
  input  logic                 sof_i,
  input  bmp2rgb_pkg::cfg_t    cfg_i,
  output logic                 res_valid_o,
  output bmp2rgb_pkg::result_t res_o
);
  import bmp2rgb_pkg::*;

  phase_e      phase_q, phase_d, ph_eff;
  logic [31:0] pos_q, pos_d, pos_eff;
  logic [31:0] fa_q, fa_d, field;
  logic [31:0] off_q, off_d;
  logic        wm_q, wm_d, hm_q, hm_d;
  logic        fmt_q, fmt_d, fmt_eff;
  logic [7:0]  blue_q, blue_d, green_q, green_d;
  logic [1:0]  cidx_q, cidx_d, cidx_eff;
  logic        pix_en;
  logic [16:0] win_x1, win_y1;

  assign field  = {byte_i, fa_q[31:8]};
  assign win_x1 = {1'b0, cfg_i.origin_x} + {1'b0, cfg_i.disp_w} - 17'd1;
  assign win_y1 = {1'b0, cfg_i.origin_y} + {1'b0, cfg_i.disp_h} - 17'd1;

  // start of image restarts parsing with this byte as file byte 0
  always_comb begin
    ph_eff   = phase_q;
    pos_eff  = pos_q;
    fmt_eff  = fmt_q;
    cidx_eff = cidx_q;
    if (sof_i) begin
      ph_eff   = PH_HEADER;
      pos_eff  = '0;
      fmt_eff  = 1'b1;
      cidx_eff = 2'd0;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    fa_d        = fa_q;
    off_d       = off_q;
    wm_d        = wm_q;
    hm_d        = hm_q;
    fmt_d       = fmt_q;
    blue_d      = blue_q;
    green_d     = green_q;
    cidx_d      = cidx_q;
    pix_en      = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (acc_i) begin
      phase_d = ph_eff;
      pos_d   = pos_eff;
      fmt_d   = fmt_eff;
      cidx_d  = cidx_eff;
      case (ph_eff)
        PH_HEADER: begin
          fa_d  = field;
          pos_d = pos_eff + 32'd1;
          case (pos_eff)
            POS_SIGNATURE: begin
              if (field[31:16] != BMP_SIGNATURE) begin
                phase_d     = PH_HALT;
                res_valid_o = 1'b1;
                res_o.kind  = KIND_ERROR;
                res_o.err   = ERR_SIGNATURE;
              end
            end
            POS_OFFSET: off_d = field;
            POS_WIDTH:  wm_d  = (field == {16'd0, cfg_i.disp_w});
            POS_HEIGHT: hm_d  = (field == {16'd0, cfg_i.disp_h});
            POS_PLANES: begin
              if (field[31:16] != BMP_PLANES) fmt_d = 1'b0;
            end
            POS_DEPTH: begin
              if (field[31:16] != BMP_BITS_PER_PIXEL) fmt_d = 1'b0;
            end
            POS_COMPRESSION: begin
              res_valid_o = 1'b1;
              if (!fmt_eff || field != 32'd0) begin
                phase_d    = PH_HALT;
                res_o.kind = KIND_ERROR;
                res_o.err  = ERR_FORMAT;
              end else if (!wm_q || !hm_q) begin
                phase_d    = PH_HALT;
                res_o.kind = KIND_ERROR;
                res_o.err  = ERR_SIZE;
              end else begin
                res_o.kind = KIND_WINDOW;
                res_o.x0   = cfg_i.origin_x;
                res_o.y0   = cfg_i.origin_y;
                res_o.x1   = win_x1;
                res_o.y1   = win_y1;
                phase_d    = (off_q <= HEADER_LEN) ? PH_PIXELS : PH_SKIP;
                cidx_d     = 2'd0;
              end
            end
            default: ;
          endcase
        end
        PH_SKIP: begin
          if (pos_eff == off_q) begin
            phase_d = PH_PIXELS;
            pix_en  = 1'b1;
          end else begin
            pos_d = pos_eff + 32'd1;
          end
        end
        PH_PIXELS: pix_en = 1'b1;
        default: ;
      endcase

      if (pix_en) begin
        case (cidx_eff)
          2'd0: begin
            blue_d = byte_i;
            cidx_d = 2'd1;
          end
          2'd1: begin
            green_d = byte_i;
            cidx_d  = 2'd2;
          end
          default: begin
            cidx_d           = 2'd0;
            res_valid_o      = 1'b1;
            res_o.kind       = KIND_PIXEL;
            res_o.pixel_word = rgb565_swapped(blue_q, green_q, byte_i);
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      pos_q   <= '0;
      fmt_q   <= 1'b1;
      cidx_q  <= 2'd0;
      wm_q    <= 1'b0;
      hm_q    <= 1'b0;
      off_q   <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      fmt_q   <= fmt_d;
      cidx_q  <= cidx_d;
      wm_q    <= wm_d;
      hm_q    <= hm_d;
      off_q   <= off_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fa_q    <= fa_d;
    blue_q  <= blue_d;
    green_q <= green_d;
  end

  a_window_leaves_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind == KIND_WINDOW |=> phase_q == PH_PIXELS || phase_q == PH_SKIP)
    else $error("window result did not move parsing past the header");

  a_error_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind == KIND_ERROR |=> phase_q == PH_HALT)
    else $error("error result did not halt parsing");

  a_halt_is_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && !sof_i && phase_q == PH_HALT |-> !res_valid_o)
    else $error("result produced while halted");

  a_cidx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cidx_q != 2'd3)
    else $error("color index out of range");

endmodule

/* hw/rtl/bmp2rgb_outbuf.sv */
module bmp2rgb_outbuf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  bmp2rgb_pkg::result_t res_i,
  output logic                 ready_o,
  bmp2rgb_out_if.source        out_o
);
  import bmp2rgb_pkg::*;

  logic    out_v_q, skid_v_q;
  result_t out_q, skid_q;
  logic    pop, load_out;

  assign pop      = out_v_q && out_o.ready;
  assign load_out = !out_v_q || pop;
  assign ready_o  = !skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (load_out) begin
      out_v_q  <= skid_v_q || push_i;
      skid_v_q <= 1'b0;
    end else if (push_i) begin
      skid_v_q <= 1'b1;
    end
  end

  // a push never coincides with a full skid stage since ready_o is low then
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= skid_v_q ? skid_q : res_i;
    end else if (push_i) begin
      skid_q <= res_i;
    end
  end

  assign out_o.valid       = out_v_q;
  assign out_o.result_kind = out_q.kind;
  assign out_o.pixel_word  = out_q.pixel_word;
  assign out_o.window_x0   = out_q.x0;
  assign out_o.window_y0   = out_q.y0;
  assign out_o.window_x1   = out_q.x1;
  assign out_o.window_y1   = out_q.y1;
  assign out_o.error_code  = out_q.err;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid stage holds a result while output stage is empty");

  a_stall_fills_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_o.ready && push_i |=> skid_v_q)
    else $error("result dropped under output stall");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && out_o.ready |=> out_v_q && !skid_v_q)
    else $error("skid stage did not drain into output stage");

endmodule

/* hw/rtl/bmp24_stream_to_rgb565.sv */
// channel   dir   handshake      payload
// in_i      in    valid/ready    data_byte[7:0], start_of_image
// out_o     out   valid/ready    result_kind, pixel_word, window_x0/y0/x1/y1, error_code
// cfg       in    cfg_we_i       cfg_idx_i[1:0], cfg_wdata_i[15:0]
//
// one byte per cycle while in_i is ready; each result is registered before out_o
// header checks, skip counter and pixel packing are combinational per accepted byte
// a two-entry output stage keeps in_i ready while one result waits on a stall
// reset returns to header parsing and loads the default display size 240 x 320
module bmp24_stream_to_rgb565 (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  bmp2rgb_in_if.sink               in_i,
  bmp2rgb_out_if.source            out_o,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [15:0]              cfg_wdata_i
);
  import bmp2rgb_pkg::*;

  cfg_t    cfg_q;
  logic    acc;
  logic    buf_ready;
  logic    res_valid;
  result_t res;

  assign in_i.ready = buf_ready;
  assign acc        = in_i.valid && buf_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x <= '0;
      cfg_q.origin_y <= '0;
      cfg_q.disp_w   <= DISP_W_RESET;
      cfg_q.disp_h   <= DISP_H_RESET;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_ORIGIN_X: cfg_q.origin_x <= cfg_wdata_i;
        REG_ORIGIN_Y: cfg_q.origin_y <= cfg_wdata_i;
        REG_DISP_W:   cfg_q.disp_w   <= cfg_wdata_i;
        REG_DISP_H:   cfg_q.disp_h   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  bmp2rgb_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .byte_i      (in_i.data_byte),
    .sof_i       (in_i.start_of_image),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  bmp2rgb_outbuf u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .res_i   (res),
    .ready_o (buf_ready),
    .out_o   (out_o)
  );

endmodule
